// File: src/two_class_ordered_fifo_top_assert.svh
// Assertion macros for the two-class ordered FIFO.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef TWO_CLASS_ORDERED_FIFO_TOP_ASSERT_SVH
`define TWO_CLASS_ORDERED_FIFO_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TCOF_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCOF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: src/tcof_pkg.sv
// Shared types and constants for the two-class ordered FIFO.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package tcof_pkg;

  localparam int DEPTH     = 16;
  localparam int ID_BITS   = 16;
  localparam int TAG_BITS  = 6;
  localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_ALL   = 2'd1,
    ACT_A     = 2'd2,
    ACT_B     = 2'd3
  } act_t;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  typedef struct packed {
    act_t               action;
    logic               item_class;
    logic [ID_BITS-1:0] item_id;
  } in_item_t;

  typedef struct packed {
    logic               item_valid;
    logic               out_class;
    logic [ID_BITS-1:0] out_id;
    logic               last;
    logic               overflow;
    logic               a_empty;
    logic               b_empty;
  } out_item_t;

  // One stored queue entry: id plus arrival tag.
  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic push;      // add the input item to its class queue
    logic pop_a;
    logic pop_b;
    logic load;      // write a result into the output register
    logic last;
    logic clr_tag;   // clear the arrival counter
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic a_ne;      // queue A holds at least one entry
    logic b_ne;
    logic a_multi;   // queue A holds two or more entries
    logic b_multi;
    logic a_first;   // head of A is older than head of B
    logic out_free;  // output register can take a result this cycle
  } dp_sts_t;

endpackage

// File: src/two_class_ordered_fifo_top.sv
// Top level of the two-class ordered FIFO: controller plus datapath.
// Depends on tcof_pkg, tcof_ctrl and tcof_dp.
//
//   channel   ports                          transfer when
//   input     in_valid  in_stall  in_item    in_valid && !in_stall
//   result    out_valid out_stall out_item   out_valid && !out_stall
//
// An add gives one result and leaves the block ready for a new item. A drain is
// accepted first, then gives one result per cycle while the output is not stalled
// (at least one result), with a single pop per cycle on the queue heads.
// Synchronous active-low reset empties both queues and clears the counter.
// A stalled output register holds the block: no pop and no new transfer.
`timescale 1ns / 1ps

module two_class_ordered_fifo_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcof_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tcof_pkg::out_item_t out_item
);
  import tcof_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  tcof_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_item.action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Queues and output register
  tcof_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: src/tcof_ctrl.sv
// Controller: accepts input transfers and sequences drains one result per cycle while the output is free.
// Depends on tcof_pkg.
`timescale 1ns / 1ps

module tcof_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tcof_pkg::act_t    in_action,
  output logic              in_stall,
  input  tcof_pkg::dp_sts_t sts,
  output tcof_pkg::dp_cmd_t cmd
);
  import tcof_pkg::*;

  state_t  state_r, state_nxt;
  act_t    action_r, action_nxt;
  logic    take_a, take_b, more;

  // State and latched drain kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      action_r <= ACT_ADD;
    end else begin
      state_r  <= state_nxt;
      action_r <= action_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    action_nxt = action_r;
    cmd        = '0;
    in_stall   = 1'b1;
    take_a     = 1'b0;
    take_b     = 1'b0;
    more       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          if (in_action == ACT_ADD) begin
            cmd.push = 1'b1;
            cmd.load = 1'b1;
            cmd.last = 1'b1;
          end else begin
            action_nxt = in_action;
            state_nxt  = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (sts.out_free) begin
          // pick the queue to pop and whether anything is left after it
          unique case (action_r)
            ACT_ALL: begin
              if (sts.a_ne && sts.b_ne) begin
                take_a = sts.a_first;
                take_b = !sts.a_first;
              end else begin
                take_a = sts.a_ne;
                take_b = sts.b_ne;
              end
              more = take_a ? (sts.a_multi || sts.b_ne) : (sts.b_multi || sts.a_ne);
            end
            ACT_A: begin
              take_a = sts.a_ne;
              more   = sts.a_multi;
            end
            ACT_B, ACT_ADD: begin
              take_b = sts.b_ne;
              more   = sts.b_multi;
            end
          endcase
          // nothing to take: one empty result closes the drain
          if (!take_a && !take_b) more = 1'b0;
          cmd.load  = 1'b1;
          cmd.pop_a = take_a;
          cmd.pop_b = take_b;
          cmd.last  = !more;
          if (!more) begin
            state_nxt   = S_IDLE;
            cmd.clr_tag = (action_r == ACT_ALL);
          end
        end
      end
    endcase
  end

endmodule

// File: src/tcof_dp.sv
// Datapath: two ring-buffer queues, arrival counter, head compare, output register.
// Depends on tcof_pkg and two_class_ordered_fifo_top_assert.svh.
`timescale 1ns / 1ps

`include "two_class_ordered_fifo_top_assert.svh"

module tcof_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tcof_pkg::in_item_t  in_item,
  input  tcof_pkg::dp_cmd_t   cmd,
  output tcof_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_stall,
  output tcof_pkg::out_item_t out_item
);
  import tcof_pkg::*;

  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);
  localparam logic [PTR_BITS:0]   DEPTH_W  = (PTR_BITS + 1)'(DEPTH);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

  entry_t                a_mem_r [DEPTH];
  entry_t                b_mem_r [DEPTH];
  logic [PTR_BITS-1:0]   a_head_r, a_head_nxt, b_head_r, b_head_nxt;
  logic [CNT_BITS-1:0]   a_cnt_r, a_cnt_nxt, b_cnt_r, b_cnt_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt, tag_diff;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;
  entry_t                a_head_ent, b_head_ent, new_ent;
  logic                  a_full, b_full, cls_full, push_a, push_b;
  logic [PTR_BITS:0]     slot_sum;
  logic [PTR_BITS-1:0]   push_slot;

  assign a_head_ent = a_mem_r[a_head_r];
  assign b_head_ent = b_mem_r[b_head_r];
  assign a_full     = (a_cnt_r == FULL_CNT);
  assign b_full     = (b_cnt_r == FULL_CNT);
  assign cls_full   = in_item.item_class ? b_full : a_full;
  assign push_a     = cmd.push && !in_item.item_class && !a_full;
  assign push_b     = cmd.push &&  in_item.item_class && !b_full;
  assign new_ent    = '{id: in_item.item_id, tag: tag_r};

  // Tail slot of the target queue, head + count wrapped at DEPTH
  always_comb begin
    if (in_item.item_class) begin
      slot_sum = {1'b0, b_head_r} + (PTR_BITS + 1)'(b_cnt_r);
    end else begin
      slot_sum = {1'b0, a_head_r} + (PTR_BITS + 1)'(a_cnt_r);
    end
    if (slot_sum >= DEPTH_W) slot_sum = slot_sum - DEPTH_W;
    push_slot = slot_sum[PTR_BITS-1:0];
  end

  // Wrap-aware age compare of the two heads
  assign tag_diff = a_head_ent.tag - b_head_ent.tag;

  always_comb begin
    sts.a_ne     = (a_cnt_r != '0);
    sts.b_ne     = (b_cnt_r != '0);
    sts.a_multi  = (a_cnt_r > CNT_BITS'(1));
    sts.b_multi  = (b_cnt_r > CNT_BITS'(1));
    sts.a_first  = tag_diff[TAG_BITS-1];
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Pointer, count and arrival counter updates
  always_comb begin
    a_head_nxt = a_head_r;
    b_head_nxt = b_head_r;
    a_cnt_nxt  = a_cnt_r;
    b_cnt_nxt  = b_cnt_r;
    tag_nxt    = tag_r;
    if (push_a) a_cnt_nxt = a_cnt_r + CNT_BITS'(1);
    if (push_b) b_cnt_nxt = b_cnt_r + CNT_BITS'(1);
    if (push_a || push_b) tag_nxt = tag_r + TAG_BITS'(1);
    if (cmd.pop_a) begin
      a_cnt_nxt  = a_cnt_r - CNT_BITS'(1);
      a_head_nxt = (a_head_r == LAST_PTR) ? '0 : a_head_r + PTR_BITS'(1);
    end
    if (cmd.pop_b) begin
      b_cnt_nxt  = b_cnt_r - CNT_BITS'(1);
      b_head_nxt = (b_head_r == LAST_PTR) ? '0 : b_head_r + PTR_BITS'(1);
    end
    if (cmd.clr_tag) tag_nxt = '0;
  end

  // Result assembly and output register handshake
  always_comb begin
    out_item_nxt            = out_item_r;
    out_valid_nxt           = out_valid_r && out_stall;
    if (cmd.load) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.item_valid = cmd.pop_a || cmd.pop_b;
      out_item_nxt.out_class  = cmd.pop_b;
      out_item_nxt.out_id     = cmd.pop_a ? a_head_ent.id :
                                cmd.pop_b ? b_head_ent.id : '0;
      out_item_nxt.last       = cmd.last;
      out_item_nxt.overflow   = cmd.push && cls_full;
      out_item_nxt.a_empty    = (a_cnt_nxt == '0);
      out_item_nxt.b_empty    = (b_cnt_nxt == '0);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_head_r    <= '0;
      b_head_r    <= '0;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      a_head_r    <= a_head_nxt;
      b_head_r    <= b_head_nxt;
      a_cnt_r     <= a_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      tag_r       <= tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Queue storage and result payload, no reset
  always_ff @(posedge clk) begin
    if (push_a) a_mem_r[push_slot] <= new_ent;
    if (push_b) b_mem_r[push_slot] <= new_ent;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `TCOF_ASSERT_NOW(a_cnt_bound, 1'b1, a_cnt_r <= FULL_CNT, "queue A count above depth")
  `TCOF_ASSERT_NOW(b_cnt_bound, 1'b1, b_cnt_r <= FULL_CNT, "queue B count above depth")
  `TCOF_ASSERT_NOW(pop_a_ok, cmd.pop_a, sts.a_ne && !cmd.pop_b, "pop of empty A or of both")
  `TCOF_ASSERT_NOW(pop_b_ok, cmd.pop_b, sts.b_ne, "pop of an empty B queue")
  `TCOF_ASSERT_NOW(load_when_free, cmd.load, sts.out_free, "load into a busy output register")
  `TCOF_ASSERT_NEXT(tag_cleared, cmd.clr_tag, tag_r == '0, "arrival counter not cleared")

endmodule

// File: verif/tb_two_class_ordered_fifo_top.sv
// Self-checking testbench for the two-class ordered FIFO top level.
// Depends on tcof_pkg and two_class_ordered_fifo_top; predicts results from its own queue model.
`timescale 1ns / 1ps

module tb_two_class_ordered_fifo_top;
  import tcof_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int RAND_ITEMS  = 36;

  typedef struct packed {
    in_item_t item;
    logic     hold;   // wait until every owed result has arrived
  } stim_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  stim_t     stim_q[$];
  out_item_t due_results[$];
  int        total_items = 1;
  int        sent_n;
  int        results_owed;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  logic [1:0] idle_phase = 2'd0;

  // Queue model state
  logic [ID_BITS-1:0]  a_id [DEPTH];
  logic [ID_BITS-1:0]  b_id [DEPTH];
  logic [TAG_BITS-1:0] a_tg [DEPTH];
  logic [TAG_BITS-1:0] b_tg [DEPTH];
  int                  a_hd, b_hd, a_cnt, b_cnt;
  logic [TAG_BITS-1:0] arr_tag;

  two_class_ordered_fifo_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #4 clk = ~clk;

  // Apply one operation to the queue model; append its results, return how many
  function automatic int apply_op(in_item_t it);
    out_item_t           r;
    int                  n;
    int                  slot;
    bit                  take_a, take_b, more;
    logic [TAG_BITS-1:0] d;
    n = 0;
    r = '0;
    if (it.action == ACT_ADD) begin
      r.last = 1'b1;
      if (it.item_class) begin
        if (b_cnt >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          slot = (b_hd + b_cnt) % DEPTH;
          b_id[slot] = it.item_id;
          b_tg[slot] = arr_tag;
          b_cnt++;
          arr_tag++;
        end
      end else begin
        if (a_cnt >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          slot = (a_hd + a_cnt) % DEPTH;
          a_id[slot] = it.item_id;
          a_tg[slot] = arr_tag;
          a_cnt++;
          arr_tag++;
        end
      end
      r.a_empty = (a_cnt == 0);
      r.b_empty = (b_cnt == 0);
      due_results.push_back(r);
      return 1;
    end
    // Drains: one pop per result until the selected queues run dry
    do begin
      take_a = 1'b0;
      take_b = 1'b0;
      case (it.action)
        ACT_ALL: begin
          if (a_cnt != 0 && b_cnt != 0) begin
            // wrap-aware age compare; equal tags let B go first
            d = a_tg[a_hd] - b_tg[b_hd];
            if (d[TAG_BITS-1]) take_a = 1'b1;
            else take_b = 1'b1;
          end else begin
            take_a = (a_cnt != 0);
            take_b = !take_a && (b_cnt != 0);
          end
        end
        ACT_A:   take_a = (a_cnt != 0);
        default: take_b = (b_cnt != 0);
      endcase
      if (take_a || take_b) begin
        r = '0;
        r.item_valid = 1'b1;
        r.out_class  = take_b;
        if (take_a) begin
          r.out_id = a_id[a_hd];
          a_hd = (a_hd + 1) % DEPTH;
          a_cnt--;
        end else begin
          r.out_id = b_id[b_hd];
          b_hd = (b_hd + 1) % DEPTH;
          b_cnt--;
        end
        case (it.action)
          ACT_ALL: more = (a_cnt != 0) || (b_cnt != 0);
          ACT_A:   more = (a_cnt != 0);
          default: more = (b_cnt != 0);
        endcase
        r.last    = !more;
        r.a_empty = (a_cnt == 0);
        r.b_empty = (b_cnt == 0);
        due_results.push_back(r);
        n++;
      end
    end while (take_a || take_b);
    // Nothing to drain: a single empty marker
    if (n == 0) begin
      r = '0;
      r.last    = 1'b1;
      r.a_empty = (a_cnt == 0);
      r.b_empty = (b_cnt == 0);
      due_results.push_back(r);
      n = 1;
    end
    if (it.action == ACT_ALL) arr_tag = '0;
    return n;
  endfunction

  task automatic cmp_field(string fname, longint unsigned want_v, longint unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic push_op(act_t op, logic cls, logic [ID_BITS-1:0] id, logic hold = 1'b0);
    stim_t s;
    s.item.action     = op;
    s.item.item_class = cls;
    s.item.item_id    = id;
    s.hold            = hold;
    stim_q.push_back(s);
  endtask

  // Mostly random ids, with the extremes mixed in
  function automatic logic [ID_BITS-1:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ID_BITS'($urandom_range(0, 65535));
  endfunction

  task automatic add_run(logic cls, int n);
    for (int j = 0; j < n; j++) push_op(ACT_ADD, cls, pick_id());
  endtask

  // Driver: predicts on each accepted transfer, then presents the next item
  always @(posedge clk) begin : drive_blk
    stim_t nxt;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_item      <= '0;
      idle_phase   <= 2'd0;
      sent_n       = 0;
      results_owed = 0;
      a_hd = 0; b_hd = 0; a_cnt = 0; b_cnt = 0;
      arr_tag = '0;
    end else begin
      if (in_valid && !in_stall) results_owed += apply_op(in_item);
      if (out_valid && !out_stall) results_owed -= 1;
      if (!in_valid || !in_stall) begin
        if (stim_q.size() != 0 && !(stim_q[0].hold && results_owed != 0) &&
            $urandom_range(0, 99) >= (idle_phase == 2'd0 ? 12 :
                                      idle_phase == 2'd1 ? 85 : 0)) begin
          nxt = stim_q.pop_front();
          in_valid <= 1'b1;
          in_item  <= nxt.item;
          sent_n++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      idle_phase <= (sent_n * 3 / total_items > 2) ? 2'd2 : 2'(sent_n * 3 / total_items);
    end
  end

  // Monitor: checks each result transfer against the oldest prediction
  always @(posedge clk) begin : mon_blk
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %p",
                   $time, out_item);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          cmp_field("item_valid", 64'(want.item_valid), 64'(out_item.item_valid));
          cmp_field("out_class",  64'(want.out_class),  64'(out_item.out_class));
          cmp_field("out_id",     64'(want.out_id),     64'(out_item.out_id));
          cmp_field("last",       64'(want.last),       64'(out_item.last));
          cmp_field("overflow",   64'(want.overflow),   64'(out_item.overflow));
          cmp_field("a_empty",    64'(want.a_empty),    64'(out_item.a_empty));
          cmp_field("b_empty",    64'(want.b_empty),    64'(out_item.b_empty));
        end
      end
      out_stall <= ($urandom_range(0, 99) < (idle_phase == 2'd0 ? 85 :
                                            idle_phase == 2'd1 ? 12 : 0));
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int k;
    act_t op;
    // Directed: drains on empty queues
    push_op(ACT_ALL, 1'b1, '1);
    push_op(ACT_A,   1'b0, '0);
    push_op(ACT_B,   1'b1, '0);
    // Id extremes in both classes, single-class drains
    push_op(ACT_ADD, 1'b0, 16'h0000);
    push_op(ACT_ADD, 1'b1, 16'hFFFF);
    push_op(ACT_ADD, 1'b0, 16'hFFFF);
    push_op(ACT_ADD, 1'b1, 16'h0000);
    push_op(ACT_A,   1'b1, 16'h5A5A, 1'b1);
    push_op(ACT_B,   1'b0, 16'hA5A5);
    // Interleaved arrivals drained in order
    push_op(ACT_ADD, 1'b1, 16'h5A5A);
    push_op(ACT_ADD, 1'b0, 16'hA5A5);
    push_op(ACT_ADD, 1'b1, 16'h1234);
    push_op(ACT_ALL, 1'b0, 16'h0000, 1'b1);

    // Tag counter now zero. Old A head at tag 0, fill both queues past full,
    // then cycle B until its tags wrap back onto the A head's tag.
    push_op(ACT_ADD, 1'b0, pick_id());
    add_run(1'b1, 16);
    add_run(1'b0, 15);
    push_op(ACT_ADD, 1'b0, pick_id());   // A full: dropped
    push_op(ACT_ADD, 1'b1, pick_id());   // B full: dropped
    push_op(ACT_B, 1'b0, pick_id(), 1'b1);
    add_run(1'b1, 16);
    push_op(ACT_B, 1'b1, pick_id());
    add_run(1'b1, 16);
    push_op(ACT_B, 1'b0, pick_id());
    add_run(1'b1, 16);                   // first of these reuses tag 0
    push_op(ACT_ALL, 1'b1, pick_id(), 1'b1);

    // Random: bursts of adds closed by a drain, some noise drains
    k = 0;
    while (k < RAND_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        op = act_t'($urandom_range(1, 3));
        push_op(op, 1'($urandom_range(0, 1)), pick_id());
        k++;
      end else begin
        int n_add;
        logic one_cls;
        n_add   = $urandom_range(1, 8);
        one_cls = 1'($urandom_range(0, 1));
        for (int j = 0; j < n_add; j++) begin
          push_op(ACT_ADD, $urandom_range(0, 1) ? one_cls : 1'($urandom_range(0, 1)),
                  pick_id());
        end
        op = act_t'($urandom_range(1, 3));
        push_op(op, 1'($urandom_range(0, 1)), pick_id(), $urandom_range(0, 4) == 0);
        k += n_add + 1;
      end
    end
    push_op(ACT_ALL, 1'b0, pick_id());
    total_items = stim_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all transfers and results, then a short settling window
    @(negedge clk);
    while (stim_q.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
